[sv/wsr_pkg.sv]
// Package for the weighted substring ranker: constants, command codes, state type.
`default_nettype none
package wsr_pkg;
    localparam int MAX_ENTRIES_D = 32;
    localparam int NAME_CHARS_D  = 63;
    localparam int HOST_CHARS_D  = 95;
    localparam int TAG_CHARS_D   = 63;
    localparam int NOTE_CHARS_D  = 127;
    localparam int QUERY_CHARS_D = 127;

    localparam logic [2:0] CMD_CLEAR  = 3'd0;
    localparam logic [2:0] CMD_ADD    = 3'd1;
    localparam logic [2:0] CMD_APPEND = 3'd2;
    localparam logic [2:0] CMD_QCLEAR = 3'd3;
    localparam logic [2:0] CMD_QAPP   = 3'd4;
    localparam logic [2:0] CMD_RANK   = 3'd5;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_ABSENT = 2'd2;
    localparam logic [1:0] ST_DROP   = 2'd3;

    localparam logic [7:0] W_NAME  = 8'd100;
    localparam logic [7:0] W_HOST  = 8'd50;
    localparam logic [7:0] W_TAGS  = 8'd30;
    localparam logic [7:0] W_NOTES = 8'd10;

    typedef enum logic [3:0] {
        S_IDLE, S_LEN, S_FSTART, S_QRD, S_CMP, S_FDONE, S_NEXTE,
        S_SEL, S_SELW, S_EMIT, S_NONE
    } t_state;
endpackage
`default_nettype wire

[sv/wsr_text_mem.sv]
// Text memory: one byte-wide synchronous RAM, one read or write per cycle.
`default_nettype none
module wsr_text_mem #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_addr,
    input  wire logic [7:0]    i_wdata,
    output logic      [7:0]    o_rdata
);
    logic [7:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

[sv/weighted_substring_ranker.sv]
// Weighted substring ranker: entry table with text fields, query and ranking.
//
// Usage: drive i_command and its operands with start while busy is low; the
// item is taken at that edge. Every command but rank yields one result, with
// o_last set, on o_valid in the cycle right after the accepting edge. busy
// stays low for these, so such items can follow back to back, one per cycle.
// Rank walks every field of every entry against the query. Each compared byte
// is read from the text and query memories, then compared. Selection then
// rescans the score registers once per emitted index, and the rank then
// closes out. busy is high for the whole rank. Results are strobed on o_valid
// for one cycle each; the receiver cannot stall. Reset clears the entry count
// and query length. The text and query memories are not cleared, since reads
// stay inside the written lengths. Field lengths sit in a register file, one
// word of four lengths per entry.
`default_nettype none
module weighted_substring_ranker
    import wsr_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_D,
    parameter int NAME_CHARS  = NAME_CHARS_D,
    parameter int HOST_CHARS  = HOST_CHARS_D,
    parameter int TAG_CHARS   = TAG_CHARS_D,
    parameter int NOTE_CHARS  = NOTE_CHARS_D,
    parameter int QUERY_CHARS = QUERY_CHARS_D
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [2:0] i_command,
    input  wire logic [4:0] i_entry_index,
    input  wire logic [1:0] i_field_select,
    input  wire logic [7:0] i_char_value,
    input  wire logic [5:0] i_result_cap,
    output logic            o_valid,
    output logic [1:0]      o_status,
    output logic [4:0]      o_result_index,
    output logic [7:0]      o_score,
    output logic            o_found,
    output logic [5:0]      o_session_count,
    output logic            o_last
);
    // Entry stride is 256 bytes per field region; address = {field, entry, pos}.
    localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int AW = 2 + EW + 8;
    localparam int QW = (QUERY_CHARS > 1) ? $clog2(QUERY_CHARS) : 1;

    t_state r_state, n_state;
    logic [6:0] r_count;
    logic [7:0] r_qlen;
    logic [3:0][7:0] r_len [MAX_ENTRIES];
    logic [7:0] r_qtext [QUERY_CHARS];
    logic [7:0] r_qrd;
    logic [7:0] r_score [MAX_ENTRIES];
    logic       r_taken [MAX_ENTRIES];

    logic [EW-1:0] r_ent;
    logic [1:0]    r_fld;
    logic [7:0]    r_pos, r_k, r_flen;
    logic [7:0]    r_acc;
    logic [5:0]    r_cap, r_nout;
    logic [EW:0]   r_scan;
    logic [EW:0]   r_ncand;
    logic          r_have;
    logic [EW-1:0] r_best;
    logic [7:0]    r_bscore;

    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_rd;

    wsr_text_mem #(.DEPTH(1 << AW), .AW(AW)) u_mem (
        .i_clk(i_clk), .i_we(mem_we), .i_addr(mem_addr),
        .i_wdata(i_char_value), .o_rdata(mem_rd)
    );

    function automatic logic [7:0] lim(input logic [1:0] f);
        case (f)
            2'd0:    lim = 8'(NAME_CHARS);
            2'd1:    lim = 8'(HOST_CHARS);
            2'd2:    lim = 8'(TAG_CHARS);
            default: lim = 8'(NOTE_CHARS);
        endcase
    endfunction

    function automatic logic [7:0] wgt(input logic [1:0] f);
        case (f)
            2'd0:    wgt = W_NAME;
            2'd1:    wgt = W_HOST;
            2'd2:    wgt = W_TAGS;
            default: wgt = W_NOTES;
        endcase
    endfunction

    logic acc;
    logic [EW-1:0] ein;
    logic          ein_ok;
    logic          q_we;
    assign acc    = start && !busy;
    assign ein    = i_entry_index[EW-1:0];
    assign ein_ok = (7'(i_entry_index) < r_count) &&
                    (32'(i_entry_index) < MAX_ENTRIES);
    assign busy   = (r_state != S_IDLE);
    assign q_we   = acc && i_command == CMD_QAPP && i_char_value != 8'd0 &&
                    32'(r_qlen) < QUERY_CHARS;

    // compare position within field
    logic [8:0] tpos;
    assign tpos = 9'(r_pos) + 9'(r_k);

    // query memory: written on query append, read at the compare offset
    always_ff @(posedge i_clk) begin
        if (q_we) begin
            r_qtext[r_qlen[QW-1:0]] <= i_char_value;
        end
        r_qrd <= r_qtext[r_k[QW-1:0]];
    end

    always_comb begin
        n_state  = r_state;
        mem_we   = 1'b0;
        mem_addr = {i_field_select, ein, r_len[ein][i_field_select]};
        case (r_state)
            S_IDLE: begin
                if (acc && i_command == CMD_APPEND && ein_ok && i_char_value != 8'd0
                    && r_len[ein][i_field_select] < lim(i_field_select)) begin
                    mem_we = 1'b1;
                end
                if (acc && i_command == CMD_RANK) begin
                    n_state = (r_count == 7'd0) ? S_NONE : S_LEN;
                end
            end
            S_LEN: n_state = S_FSTART;
            S_FSTART: begin
                if (r_qlen == 8'd0) n_state = S_FDONE;
                else if (r_qlen > r_flen || 9'(r_pos) + 9'(r_qlen) > 9'(r_flen))
                    n_state = S_NEXTE;
                else n_state = S_QRD;
            end
            S_QRD: begin
                mem_addr = {r_fld, r_ent, tpos[7:0]};
                n_state  = S_CMP;
            end
            S_CMP: begin
                if (mem_rd != r_qrd) n_state = S_FSTART;
                else if (r_k + 8'd1 == r_qlen) n_state = S_FDONE;
                else n_state = S_QRD;
            end
            S_FDONE: n_state = S_NEXTE;
            S_NEXTE: begin
                if (r_fld == 2'd3 && 7'(r_ent) + 7'd1 == r_count) n_state = S_SEL;
                else n_state = S_LEN;
            end
            S_SEL: n_state = (r_nout >= r_cap) ? S_NONE : S_SELW;
            S_SELW: n_state = (32'(r_scan) == MAX_ENTRIES) ? S_EMIT : S_SELW;
            S_EMIT: n_state = (r_have) ? S_SEL : S_NONE;
            S_NONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_qlen  <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= 1'b0;
            case (r_state)
            S_IDLE: if (acc) begin
                o_valid  <= (i_command != CMD_RANK);
                o_status <= ST_OK; o_result_index <= '0; o_score <= '0;
                o_found  <= 1'b0; o_last <= 1'b1;
                case (i_command)
                    CMD_CLEAR: r_count <= '0;
                    CMD_ADD: begin
                        if (32'(r_count) >= MAX_ENTRIES) o_status <= ST_FULL;
                        else begin
                            r_len[r_count[EW-1:0]] <= '0;
                            r_count <= r_count + 7'd1;
                            o_found <= 1'b1;
                            o_result_index <= 5'(r_count);
                        end
                    end
                    CMD_APPEND: begin
                        if (!ein_ok) o_status <= ST_ABSENT;
                        else if (i_char_value == 8'd0) o_status <= ST_OK;
                        else if (r_len[ein][i_field_select] >= lim(i_field_select))
                            o_status <= ST_DROP;
                        else r_len[ein][i_field_select] <=
                                 r_len[ein][i_field_select] + 8'd1;
                    end
                    CMD_QCLEAR: r_qlen <= '0;
                    CMD_QAPP: begin
                        if (i_char_value != 8'd0) begin
                            if (32'(r_qlen) >= QUERY_CHARS) o_status <= ST_DROP;
                            else r_qlen <= r_qlen + 8'd1;
                        end
                    end
                    CMD_RANK: begin
                        r_ent <= '0; r_fld <= '0; r_acc <= '0; r_nout <= '0;
                        r_cap <= (i_result_cap > 6'd32) ? 6'd32 : i_result_cap;
                        for (int e = 0; e < MAX_ENTRIES; e++) r_taken[e] <= 1'b0;
                    end
                    default: ;
                endcase
            end
            S_LEN: begin
                r_flen <= r_len[r_ent][r_fld];
                r_pos <= '0; r_k <= '0;
            end
            S_FSTART: r_k <= '0;
            S_QRD: ;
            S_CMP: begin
                if (mem_rd != r_qrd) begin
                    r_pos <= r_pos + 8'd1;
                end else begin
                    r_k <= r_k + 8'd1;
                end
            end
            S_FDONE: r_acc <= r_acc + wgt(r_fld);
            S_NEXTE: begin
                r_fld <= r_fld + 2'd1;
                if (r_fld == 2'd3) begin
                    r_score[r_ent] <= r_acc;
                    r_acc <= '0;
                    r_ent <= r_ent + 1'b1;
                end
            end
            S_SEL: begin
                r_scan <= '0; r_have <= 1'b0; r_best <= '0; r_bscore <= '0;
                r_ncand <= '0;
            end
            S_SELW: if (32'(r_scan) < MAX_ENTRIES) begin
                // count every candidate left so the final index can be marked
                if (7'(r_scan) < r_count && !r_taken[r_scan[EW-1:0]] &&
                    r_score[r_scan[EW-1:0]] != 8'd0) begin
                    r_ncand <= r_ncand + 1'b1;
                    if (r_score[r_scan[EW-1:0]] > r_bscore) begin
                        r_have <= 1'b1;
                        r_best <= r_scan[EW-1:0];
                        r_bscore <= r_score[r_scan[EW-1:0]];
                    end
                end
                r_scan <= r_scan + 1'b1;
            end
            S_EMIT: if (r_have) begin
                r_taken[r_best] <= 1'b1;
                r_nout <= r_nout + 6'd1;
                o_valid <= 1'b1; o_status <= ST_OK; o_found <= 1'b1;
                o_result_index <= 5'(r_best); o_score <= r_bscore;
                o_last <= (r_nout + 6'd1 == r_cap) ||
                          (r_ncand == {{EW{1'b0}}, 1'b1});
            end
            S_NONE: begin
                // emit the lone empty result when nothing was ranked
                if (r_nout == 6'd0) begin
                    o_valid <= 1'b1; o_status <= ST_OK; o_found <= 1'b0;
                    o_result_index <= '0; o_score <= '0; o_last <= 1'b1;
                end
            end
            default: ;
            endcase
        end
    end

    assign o_session_count = r_count[5:0];
endmodule
`default_nettype wire
